/* rtl/core/pecf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pecf_pkg;

  // digit width of the serial multiplier; must divide 16 and 24 (1, 2, 4 or 8)
  localparam int DEF_DIGIT_W = 4;

  // exact difference of two 32-bit signed values
  localparam int DIFF_W = 33;

  localparam int SMOOTH_GAIN_W = 17;
  localparam int Q24_GAIN_W    = 25;
  localparam int CFG_DATA_W    = 25;
  localparam int CFG_ADDR_W    = 2;

  localparam logic [SMOOTH_GAIN_W-1:0] SMOOTH_ONE = 17'h1_0000;
  localparam logic [Q24_GAIN_W-1:0]    Q24_ONE    = 25'h100_0000;

  localparam logic [SMOOTH_GAIN_W-1:0] SMOOTH_GAIN_RST    = 17'd19661;
  localparam logic [Q24_GAIN_W-1:0]    BIAS_GAIN_RST      = 25'd11177;
  localparam logic [Q24_GAIN_W-1:0]    OFS_LEARN_GAIN_RST = 25'd8389;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTH_GAIN    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FUSION_ENABLE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_GAIN      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFS_LEARN_GAIN = 2'd3;

  // controller modes
  localparam logic [7:0] MODE_NORMAL = 8'd0;
  localparam logic [7:0] MODE_SPIN_A = 8'd1;
  localparam logic [7:0] MODE_SPIN_B = 8'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] yaw_in;
    logic signed [31:0] ctrl_yaw;
    logic               ctrl_yaw_valid;
    logic        [7:0]  ctrl_mode;
  } pecf_in_t;

  typedef struct packed {
    logic signed [31:0] smooth_x;
    logic signed [31:0] smooth_y;
    logic signed [31:0] smooth_yaw;
    logic signed [31:0] clean_yaw;
  } pecf_out_t;

  // multiply request: step = round(d * g / 2^s), s = 24 when q24 else 16
  typedef struct packed {
    logic                     start;
    logic                     q24;
    logic signed [DIFF_W-1:0] d;
    logic [Q24_GAIN_W-1:0]    g;
  } pecf_mreq_t;

  typedef struct packed {
    logic        done;
    logic [31:0] step;
  } pecf_mres_t;

endpackage

`default_nettype wire

/* rtl/core/pose_ema_yaw_complementary_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       request    in_valid / in_ready    in_data  (pecf_in_t)
// out      result     out_valid / out_ready  out_data (pecf_out_t)
// cfg      write      cfg_we                 cfg_addr, cfg_data
//
// One request at a time. Each multiply runs through a shared digit-serial
// multiplier, D = DIGIT_W bits a cycle, over the s-bit gain fraction (s = 16 or 24).
// Bypassed or first samples skip the pose multiplies.
// rst is synchronous and restores register defaults and clears filter state.
// A result held by out_ready low blocks the next request only at its end.
module pose_ema_yaw_complementary_filter #(
  parameter int DIGIT_W = pecf_pkg::DEF_DIGIT_W
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  pecf_pkg::pecf_in_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output pecf_pkg::pecf_out_t                out_data,
  input  wire                                cfg_we,
  input  wire  [pecf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [pecf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pecf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_MYAW,
    S_FUSE,
    S_ALIGN,
    S_MOFS,
    S_MBIAS,
    S_DONE
  } state_t;

  state_t state;

  logic [SMOOTH_GAIN_W-1:0] smooth_gain;
  logic                     fusion_enable;
  logic [Q24_GAIN_W-1:0]    bias_gain;
  logic [Q24_GAIN_W-1:0]    ofs_learn_gain;

  logic [31:0] filt_x;
  logic [31:0] filt_y;
  logic [31:0] filt_yaw;
  logic        smooth_started;
  logic [31:0] yaw_offset;
  logic        offset_started;
  logic [31:0] yaw_bias;

  pecf_in_t    inr;
  logic        byp;
  logic [31:0] clean;

  pecf_mreq_t  mreq;
  pecf_mres_t  mres;

  logic [SMOOTH_GAIN_W-1:0] sg;
  logic [Q24_GAIN_W-1:0]    bg;
  logic [Q24_GAIN_W-1:0]    og;
  logic [Q24_GAIN_W-1:0]    bg_eff;
  logic [31:0]              syaw;
  logic [31:0]              aligned;
  logic [DIFF_W-1:0]        dy;
  logic [31:0]              dyaw;
  logic [31:0]              dofs;
  logic [31:0]              dbias;
  logic [31:0]              bias_new;

  // clamp gains above one
  assign sg = (smooth_gain > SMOOTH_ONE) ? SMOOTH_ONE : smooth_gain;
  assign bg = (bias_gain > Q24_ONE) ? Q24_ONE : bias_gain;
  assign og = (ofs_learn_gain > Q24_ONE) ? Q24_ONE : ofs_learn_gain;

  always_comb begin
    bg_eff = bg;
    // freeze the bias while spinning
    if (inr.ctrl_mode inside {MODE_SPIN_A, MODE_SPIN_B}) begin
      bg_eff = '0;
    end
  end

  assign syaw     = byp ? inr.yaw_in : filt_yaw;
  assign aligned  = inr.ctrl_yaw + yaw_offset;
  assign dy       = {inr.pos_y[31], inr.pos_y} - {filt_y[31], filt_y};
  assign dyaw     = inr.yaw_in - filt_yaw;
  assign dofs     = syaw - aligned;
  assign dbias    = (aligned - syaw) - yaw_bias;
  assign bias_new = yaw_bias + mres.step;

  assign in_ready = (state == S_IDLE);

  pecf_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .res (mres)
  );

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SMOOTH_GAIN:    smooth_gain    <= cfg_data[SMOOTH_GAIN_W-1:0];
        CFG_FUSION_ENABLE:  fusion_enable  <= cfg_data[0];
        CFG_BIAS_GAIN:      bias_gain      <= cfg_data[Q24_GAIN_W-1:0];
        CFG_OFS_LEARN_GAIN: ofs_learn_gain <= cfg_data[Q24_GAIN_W-1:0];
        default: ;
      endcase
    end
    if (rst) begin
      smooth_gain    <= SMOOTH_GAIN_RST;
      fusion_enable  <= 1'b1;
      bias_gain      <= BIAS_GAIN_RST;
      ofs_learn_gain <= OFS_LEARN_GAIN_RST;
    end
  end

  always_ff @(posedge clk) begin
    mreq.start <= 1'b0;
    if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          inr <= in_data;
          if (sg == '0) begin
            byp   <= 1'b1;
            state <= S_FUSE;
          end else if (!smooth_started) begin
            byp            <= 1'b0;
            filt_x         <= in_data.pos_x;
            filt_y         <= in_data.pos_y;
            filt_yaw       <= in_data.yaw_in;
            smooth_started <= 1'b1;
            state          <= S_FUSE;
          end else begin
            byp        <= 1'b0;
            mreq.start <= 1'b1;
            mreq.q24   <= 1'b0;
            mreq.d     <= {in_data.pos_x[31], in_data.pos_x} - {filt_x[31], filt_x};
            mreq.g     <= Q24_GAIN_W'(sg);
            state      <= S_MX;
          end
        end
      end
      S_MX: begin
        if (mres.done) begin
          filt_x     <= filt_x + mres.step;
          mreq.start <= 1'b1;
          mreq.d     <= dy;
          state      <= S_MY;
        end
      end
      S_MY: begin
        if (mres.done) begin
          filt_y     <= filt_y + mres.step;
          mreq.start <= 1'b1;
          mreq.d     <= {dyaw[31], dyaw};
          state      <= S_MYAW;
        end
      end
      S_MYAW: begin
        if (mres.done) begin
          filt_yaw <= filt_yaw + mres.step;
          state    <= S_FUSE;
        end
      end
      S_FUSE: begin
        if (fusion_enable && inr.ctrl_yaw_valid) begin
          if (!offset_started) begin
            yaw_offset     <= syaw - inr.ctrl_yaw;
            offset_started <= 1'b1;
          end
          state <= S_ALIGN;
        end else begin
          clean <= syaw;
          state <= S_DONE;
        end
      end
      S_ALIGN: begin
        mreq.start <= 1'b1;
        mreq.q24   <= 1'b1;
        if (inr.ctrl_mode == MODE_NORMAL) begin
          mreq.d <= {dofs[31], dofs};
          mreq.g <= og;
          state  <= S_MOFS;
        end else begin
          mreq.d <= {dbias[31], dbias};
          mreq.g <= bg_eff;
          state  <= S_MBIAS;
        end
      end
      S_MOFS: begin
        // the bias sees the offset from before this update
        if (mres.done) begin
          yaw_offset <= yaw_offset + mres.step;
          mreq.start <= 1'b1;
          mreq.d     <= {dbias[31], dbias};
          mreq.g     <= bg_eff;
          state      <= S_MBIAS;
        end
      end
      S_MBIAS: begin
        if (mres.done) begin
          yaw_bias <= bias_new;
          clean    <= syaw + bias_new;
          state    <= S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          out_data.smooth_x   <= byp ? inr.pos_x : filt_x;
          out_data.smooth_y   <= byp ? inr.pos_y : filt_y;
          out_data.smooth_yaw <= syaw;
          out_data.clean_yaw  <= clean;
          out_valid           <= 1'b1;
          state               <= S_IDLE;
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      mreq.start     <= 1'b0;
      filt_x         <= '0;
      filt_y         <= '0;
      filt_yaw       <= '0;
      smooth_started <= 1'b0;
      yaw_offset     <= '0;
      offset_started <= 1'b0;
      yaw_bias       <= '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pecf_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module pecf_mul #(
  parameter int DIGIT_W = pecf_pkg::DEF_DIGIT_W
) (
  input  wire                 clk,
  input  wire                 rst,
  input  pecf_pkg::pecf_mreq_t req,
  output pecf_pkg::pecf_mres_t res
);

  import pecf_pkg::*;

  localparam int ACC_W = DIFF_W + DIGIT_W + 1;
  localparam int GSH_W = 24;
  localparam int N16   = 16 / DIGIT_W;
  localparam int N24   = 24 / DIGIT_W;
  localparam int CNT_W = $clog2(N24 + 1);

  logic                     busy;
  logic                     done;
  logic [CNT_W-1:0]         cnt;
  logic [GSH_W-1:0]         gsh;
  logic signed [DIFF_W-1:0] dreg;
  logic signed [ACC_W-1:0]  acc;
  logic                     rbit;
  logic                     full;

  logic [DIGIT_W-1:0]       digit;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  sum;

  assign digit = gsh[DIGIT_W-1:0];
  assign prod  = $signed({{(ACC_W-DIFF_W){dreg[DIFF_W-1]}}, dreg}) *
                 $signed({{(ACC_W-DIGIT_W){1'b0}}, digit});
  assign sum   = acc + prod;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (req.start) begin
      busy <= 1'b1;
      acc  <= '0;
      rbit <= 1'b0;
      dreg <= req.d;
      gsh  <= req.g[GSH_W-1:0];
      // a gain of exactly one passes the difference straight through
      full <= req.q24 ? req.g[24] : req.g[16];
      cnt  <= req.q24 ? CNT_W'(N24) : CNT_W'(N16);
    end else if (busy) begin
      // add one digit's partial product, drop the settled low bits
      acc  <= sum >>> DIGIT_W;
      rbit <= sum[DIGIT_W-1];
      gsh  <= gsh >> DIGIT_W;
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  // floor(P / 2^s) plus the bit just below the cut rounds half up
  assign res.done = done;
  assign res.step = full ? dreg[31:0] : (acc[31:0] + {31'b0, rbit});

endmodule

`default_nettype wire

/* dv/pose_ema_yaw_complementary_filter_test.sv */
`timescale 1ns / 1ps

module pose_ema_yaw_complementary_filter_test;
  import pecf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pecf_in_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pecf_out_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SMOOTH_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pose_ema_yaw_complementary_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // register shadow
  logic [SMOOTH_GAIN_W-1:0] gain_smooth = SMOOTH_GAIN_RST;
  logic                     fusion_on   = 1'b1;
  logic [Q24_GAIN_W-1:0]    gain_bias   = BIAS_GAIN_RST;
  logic [Q24_GAIN_W-1:0]    gain_offset = OFS_LEARN_GAIN_RST;

  // filter state shadow
  logic [31:0] filt_x_m      = '0;
  logic [31:0] filt_y_m      = '0;
  logic [31:0] filt_yaw_m    = '0;
  logic        ema_loaded    = 1'b0;
  logic [31:0] yaw_off_m     = '0;
  logic        offset_loaded = 1'b0;
  logic [31:0] yaw_bias_m    = '0;

  pecf_in_t  sample_q[$];
  pecf_out_t pose_due_q[$];

  int mismatches = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int send_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  // trajectory used to build realistic request streams
  int traj_x, traj_y, traj_yaw, traj_off;

  // round half up of d * g / 2^s
  function automatic longint round_gain(longint d, longint g, int s);
    longint t;
    t = d * g + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic logic [31:0] ema_lin(logic [31:0] f, logic [31:0] smp, longint g);
    longint d;
    d = longint'($signed(smp)) - longint'($signed(f));
    return 32'(longint'($signed(f)) + round_gain(d, g, 16));
  endfunction

  function automatic logic [31:0] angle_step(logic [31:0] base, logic [31:0] diff,
                                             longint g, int s);
    return base + 32'(round_gain(longint'($signed(diff)), g, s));
  endfunction

  function automatic pecf_out_t predict_pose(pecf_in_t smp);
    pecf_out_t   res;
    longint      sg, bg, og, g;
    logic [31:0] sx, sy, syaw, clean, aligned;
    sg = (gain_smooth > SMOOTH_ONE) ? longint'(SMOOTH_ONE) : longint'(gain_smooth);
    bg = (gain_bias > Q24_ONE) ? longint'(Q24_ONE) : longint'(gain_bias);
    og = (gain_offset > Q24_ONE) ? longint'(Q24_ONE) : longint'(gain_offset);
    sx = smp.pos_x;
    sy = smp.pos_y;
    syaw = smp.yaw_in;
    if (sg != 0) begin
      if (!ema_loaded) begin
        filt_x_m = smp.pos_x;
        filt_y_m = smp.pos_y;
        filt_yaw_m = smp.yaw_in;
        ema_loaded = 1'b1;
      end else begin
        filt_x_m = ema_lin(filt_x_m, smp.pos_x, sg);
        filt_y_m = ema_lin(filt_y_m, smp.pos_y, sg);
        filt_yaw_m = angle_step(filt_yaw_m, smp.yaw_in - filt_yaw_m, sg, 16);
      end
      sx = filt_x_m;
      sy = filt_y_m;
      syaw = filt_yaw_m;
    end
    clean = syaw;
    if (fusion_on && smp.ctrl_yaw_valid) begin
      if (!offset_loaded) begin
        yaw_off_m = syaw - smp.ctrl_yaw;
        offset_loaded = 1'b1;
      end
      aligned = smp.ctrl_yaw + yaw_off_m;
      if (smp.ctrl_mode == MODE_NORMAL)
        yaw_off_m = angle_step(yaw_off_m, syaw - aligned, og, 24);
      // spinning freezes the bias
      g = (smp.ctrl_mode == MODE_SPIN_A || smp.ctrl_mode == MODE_SPIN_B) ? 0 : bg;
      yaw_bias_m = angle_step(yaw_bias_m, aligned - syaw - yaw_bias_m, g, 24);
      clean = syaw + yaw_bias_m;
    end
    res.smooth_x = sx;
    res.smooth_y = sy;
    res.smooth_yaw = syaw;
    res.clean_yaw = clean;
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready)
        pose_due_q.push_back(predict_pose(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            send_gap = $urandom_range(1, 17) - 1;
            in_valid <= 1'b0;
          end else begin
            in_data <= sample_q.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pecf_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_due_q.size() == 0) begin
          note_mismatch("result with nothing pending", out_data.smooth_x, '0);
        end else begin
          want = pose_due_q.pop_front();
          if (out_data.smooth_x !== want.smooth_x)
            note_mismatch("smooth_x", out_data.smooth_x, want.smooth_x);
          if (out_data.smooth_y !== want.smooth_y)
            note_mismatch("smooth_y", out_data.smooth_y, want.smooth_y);
          if (out_data.smooth_yaw !== want.smooth_yaw)
            note_mismatch("smooth_yaw", out_data.smooth_yaw, want.smooth_yaw);
          if (out_data.clean_yaw !== want.clean_yaw)
            note_mismatch("clean_yaw", out_data.clean_yaw, want.clean_yaw);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: only counts while something is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && sample_q.size() == 0 && pose_due_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pecf_in_t mk_sample(logic [31:0] x, logic [31:0] y, logic [31:0] yaw,
                                         logic [31:0] cyaw, logic cvalid, logic [7:0] mode);
    pecf_in_t s;
    s.pos_x = x;
    s.pos_y = y;
    s.yaw_in = yaw;
    s.ctrl_yaw = cyaw;
    s.ctrl_yaw_valid = cvalid;
    s.ctrl_mode = mode;
    return s;
  endfunction

  // sample on the falling edge so the driver's updates have settled
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pose_due_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    case (addr)
      CFG_SMOOTH_GAIN:    gain_smooth = data[SMOOTH_GAIN_W-1:0];
      CFG_FUSION_ENABLE:  fusion_on = data[0];
      CFG_BIAS_GAIN:      gain_bias = data;
      CFG_OFS_LEARN_GAIN: gain_offset = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_samples(int n);
    pecf_in_t item;
    int       pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        item = mk_sample($urandom, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        if (pick < 16) begin
          // start a new segment somewhere else
          traj_x = $urandom;
          traj_y = $urandom;
          traj_yaw = $urandom;
          traj_off = $urandom;
        end
        traj_x = traj_x + int'($urandom_range(0, 4000)) - 2000;
        traj_y = traj_y + int'($urandom_range(0, 4000)) - 2000;
        traj_yaw = traj_yaw + int'($urandom_range(0, 1 << 25)) - (1 << 24);
        item.pos_x = traj_x + int'($urandom_range(0, 64)) - 32;
        item.pos_y = traj_y + int'($urandom_range(0, 64)) - 32;
        item.yaw_in = traj_yaw + int'($urandom_range(0, 1 << 16)) - (1 << 15);
        item.ctrl_yaw = traj_yaw - traj_off + int'($urandom_range(0, 1 << 18)) - (1 << 17);
        item.ctrl_yaw_valid = ($urandom_range(0, 19) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 65)
          item.ctrl_mode = MODE_NORMAL;
        else if (pick < 80)
          item.ctrl_mode = MODE_SPIN_A;
        else if (pick < 90)
          item.ctrl_mode = MODE_SPIN_B;
        else
          item.ctrl_mode = 8'($urandom_range(3, 255));
      end
      sample_q.push_back(item);
    end
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] smooth, logic [CFG_DATA_W-1:0] fusion,
                           logic [CFG_DATA_W-1:0] bias, logic [CFG_DATA_W-1:0] offs,
                           int n, int gap_pct, int stall_pct);
    drain();
    write_reg(CFG_SMOOTH_GAIN, smooth);
    write_reg(CFG_FUSION_ENABLE, fusion);
    write_reg(CFG_BIAS_GAIN, bias);
    write_reg(CFG_OFS_LEARN_GAIN, offs);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    // hold half the requests back until the first half has fully drained
    queue_samples(n / 2);
    drain();
    queue_samples(n - n / 2);
    drain();
  endtask

  initial begin
    traj_x = 0;
    traj_y = 0;
    traj_yaw = 0;
    traj_off = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed requests at reset gains; first sample without controller yaw
    in_gap_pct = 20;
    out_stall_pct = 20;
    sample_q.push_back(mk_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h0, 1'b0, MODE_NORMAL));
    sample_q.push_back(mk_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h1234_5678, 1'b1, MODE_NORMAL));
    sample_q.push_back(mk_sample(32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, MODE_SPIN_A));
    sample_q.push_back(mk_sample(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                                 32'h7FFF_FFFF, 1'b1, MODE_SPIN_B));
    sample_q.push_back(mk_sample(32'h8000_0000, 32'h8000_0000, 32'h4000_0000,
                                 32'hC000_0000, 1'b1, 8'd3));
    sample_q.push_back(mk_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hC000_0000,
                                 32'h4000_0000, 1'b1, 8'd255));
    sample_q.push_back(mk_sample(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001,
                                 32'h7FFF_FFFF, 1'b1, MODE_NORMAL));
    sample_q.push_back(mk_sample(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001,
                                 32'h8000_0000, 1'b0, MODE_NORMAL));
    sample_q.push_back(mk_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                 32'hAAAA_AAAA, 1'b1, 8'h55));
    sample_q.push_back(mk_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                 32'h5555_5555, 1'b1, 8'hAA));
    sample_q.push_back(mk_sample(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, MODE_NORMAL));
    sample_q.push_back(mk_sample(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, MODE_NORMAL));
    drain();

    // bypass with unity fusion gains
    run_phase(25'd0, 25'd1, 25'h100_0000, 25'h100_0000, 120, 10, 10);
    // unity smoothing, fusion off
    run_phase(25'h1_0000, 25'd0, 25'd0, 25'd0, 120, 30, 0);
    // every gain above one; smoothing keeps only its low 17 bits
    run_phase(25'h1FF_FFFF, 25'd1, 25'h1FF_FFFF, 25'h1FF_FFFF, 120, 0, 30);
    run_phase(25'd1, 25'd1, 25'd1, 25'd1, 120, 15, 15);
    // fusion bit cleared by an even write
    run_phase(25'd40000, 25'h1FF_FFFE, 25'd5000000, 25'd300000, 120, 5, 40);
    for (int p = 0; p < 4; p++)
      run_phase(25'($urandom_range(0, 70000)), 25'd1,
                25'($urandom_range(0, 32'h100_0100)), 25'($urandom_range(0, 32'h100_0100)),
                130, $urandom_range(0, 40), $urandom_range(0, 40));
    // back to reset gains, no idling to the end
    run_phase(25'(SMOOTH_GAIN_RST), 25'd1, 25'(BIAS_GAIN_RST), 25'(OFS_LEARN_GAIN_RST),
              150, 0, 0);

    repeat (120) @(posedge clk);
    if (mismatches == 0 && pose_due_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
